/* hw/rtl/assert_macros.svh */
// assertion macros shared by the rtl of the word wrapper
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a condition that holds at every clock edge out of reset
`define ASSERT_HOLDS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error(msg);

// a condition that implies another in the same cycle
`define ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// a condition that implies another in the following cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/gww_pkg.sv */
// package of types, codes and constants for the greedy word wrapper
`timescale 1ns / 1ps

package gww_pkg;

   // default storage widths
   localparam int PIXEL_BITS_DEF = 16;
   localparam int COUNT_BITS_DEF = 12;

   // fixed field widths
   localparam int CODE_W      = 21;
   localparam int METRIC_W    = 8;
   localparam int OUT_PIX_W   = 16;
   localparam int OUT_CNT_W   = 12;
   localparam int BOUND_W     = 16;
   localparam int SPACING_W   = 8;
   localparam int REQ_DATA_W  = 48;
   localparam int RSP_DATA_W  = 56;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 16;

   // register reset values
   localparam logic [BOUND_W-1:0]   WIDTH_BOUND_RST = 16'd640;
   localparam logic [SPACING_W-1:0] MIN_SPACING_RST = 8'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH_BOUND = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_SPACING = 1'b1;

   // request kinds
   localparam logic REQ_CHAR = 1'b0;
   localparam logic REQ_END  = 1'b1;

   // character codes with a meaning of their own
   localparam logic [CODE_W-1:0] CHAR_SPACE   = 21'd32;
   localparam logic [CODE_W-1:0] CHAR_NEWLINE = 21'd10;
   localparam logic [CODE_W-1:0] CHAR_TAB     = 21'd9;
   localparam logic [CODE_W-1:0] CHAR_CR      = 21'd13;

   typedef enum logic [2:0] {
      CLS_NORMAL,
      CLS_SPACE,
      CLS_NEWLINE,
      CLS_IGNORED,
      CLS_END
   } char_class_type;

   // one emitted line
   typedef struct packed {
      logic [OUT_PIX_W-1:0] line_width;
      logic [OUT_CNT_W-1:0] word_count;
      logic [OUT_CNT_W-1:0] char_count;
      logic [METRIC_W-1:0]  line_height;
      logic [METRIC_W-1:0]  line_ascender;
      logic                 wrapped;
      logic                 last;
   } rsp_rec_type;

   // sort an item into its class
   function automatic char_class_type classify(input logic req_kind,
                                               input logic [CODE_W-1:0] code);
      if (req_kind == REQ_END) begin
         classify = CLS_END;
      end else begin
         unique case (code) inside
            CHAR_SPACE:        classify = CLS_SPACE;
            CHAR_NEWLINE:      classify = CLS_NEWLINE;
            CHAR_TAB, CHAR_CR: classify = CLS_IGNORED;
            default:           classify = CLS_NORMAL;
         endcase
      end
   endfunction

endpackage

/* hw/rtl/greedy_word_wrap_top.sv */
// top level of the greedy word wrapper
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Greedy word wrapper, one character per req transaction.
// req: tuser is the kind (0 character, 1 end of text), tdata carries the
//   character code and the glyph advance, height and ascender.
// rsp: one transaction per emitted line with width, word and character
//   counts, tallest height and ascender; tuser is set when the line was
//   broken by width overflow, tlast marks the final line caused by a request.
// csr: index 0 is width_bound, index 1 is min_spacing; always ready. The user
//   must see that it is written only while no request is in flight; the block does not enforce this.
// A request accepted into the request register has its first line loaded
//   into the rsp register as it leaves the request register. Throughput is
//   one request per cycle while rsp does not stall; an end of text that yields
//   two lines fills both result slots, which leave through rsp in turn.
// The update path is one 8 x COUNT_BITS multiply, a three-term add and a
//   compare between the request register and the line register.
// Reset clears line and word state and restores width_bound 640, spacing 4.
// When rsp stalls, the request register keeps one item and ordinary and ignored
//   characters keep flowing; spaces, newlines and end of text wait for room.
module greedy_word_wrap_top #(
   parameter int PIXEL_BITS = gww_pkg::PIXEL_BITS_DEF,
   parameter int COUNT_BITS = gww_pkg::COUNT_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // char_code[20:0], glyph_advance[28:21], glyph_height[36:29],
   // glyph_ascender[44:37], zero fill
   input  logic [gww_pkg::REQ_DATA_W-1:0]  req_tdata,
   // req_type
   input  logic                            req_tuser,
   // result channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // line_width[15:0], word_count[27:16], char_count[39:28],
   // line_height[47:40], line_ascender[55:48]
   output logic [gww_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // wrapped
   output logic                            rsp_tuser,
   output logic                            rsp_tlast,
   // register write channel
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [gww_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [gww_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import gww_pkg::*;

   localparam int PW     = PIXEL_BITS;
   localparam int CW     = COUNT_BITS;
   localparam int PROD_W = SPACING_W + CW;
   localparam int SUM_W  = ((PW > PROD_W) ? PW : PROD_W) + 2;

   // configuration registers
   logic [BOUND_W-1:0]   width_bound_ff, width_bound_in;
   logic [SPACING_W-1:0] min_spacing_ff, min_spacing_in;

   // request register
   logic                 s1_valid_ff, s1_valid_in;
   logic                 s1_kind_ff, s1_kind_in;
   logic [CODE_W-1:0]    s1_code_ff, s1_code_in;
   logic [METRIC_W-1:0]  s1_adv_ff, s1_adv_in;
   logic [METRIC_W-1:0]  s1_hgt_ff, s1_hgt_in;
   logic [METRIC_W-1:0]  s1_asc_ff, s1_asc_in;

   // line and word state
   logic [PW-1:0]        line_sum_ff, line_sum_in;
   logic [CW-1:0]        line_words_ff, line_words_in;
   logic [CW-1:0]        line_chars_ff, line_chars_in;
   logic [METRIC_W-1:0]  line_hgt_ff, line_hgt_in;
   logic [METRIC_W-1:0]  line_asc_ff, line_asc_in;
   logic [PW-1:0]        word_sum_ff, word_sum_in;
   logic [CW-1:0]        word_chars_ff, word_chars_in;
   logic [METRIC_W-1:0]  word_hgt_ff, word_hgt_in;
   logic [METRIC_W-1:0]  word_asc_ff, word_asc_in;

   // result slots: head on the port, second behind it
   logic                 s2a_valid_ff, s2a_valid_in;
   rsp_rec_type          s2a_rec_ff, s2a_rec_in;
   logic                 s2b_valid_ff, s2b_valid_in;
   rsp_rec_type          s2b_rec_ff, s2b_rec_in;

   // datapath
   char_class_type       s1_cls;
   logic                 quiet;
   logic                 out_free;
   logic                 s1_go;
   logic                 req_fire;
   logic                 rsp_fire;
   logic                 load;
   logic [1:0]           res_cnt;
   rsp_rec_type          res0, res1;
   logic [CW-1:0]        gaps;
   logic [PROD_W-1:0]    spacing_prod;
   logic [SUM_W-1:0]     proposed;
   logic                 overflow;
   logic [PW:0]          merged_sum_raw;
   logic [PW-1:0]        merged_sum;
   logic [CW:0]          merged_words_raw;
   logic [CW-1:0]        merged_words;
   logic [CW:0]          merged_chars_raw;
   logic [CW-1:0]        merged_chars;
   logic [METRIC_W-1:0]  merged_hgt;
   logic [METRIC_W-1:0]  merged_asc;
   logic [PW:0]          word_sum_raw;
   logic [CW:0]          word_chars_raw;

   // pack line state into an output record, fields cut to their port widths
   function automatic rsp_rec_type make_rec(input logic [PW-1:0] sum,
                                            input logic [CW-1:0] words,
                                            input logic [CW-1:0] chars,
                                            input logic [METRIC_W-1:0] hgt,
                                            input logic [METRIC_W-1:0] asc,
                                            input logic wrapped,
                                            input logic last);
      rsp_rec_type rec;
      logic [31:0] sum_ext;
      logic [31:0] words_ext;
      logic [31:0] chars_ext;
      sum_ext   = 32'(sum);
      words_ext = 32'(words);
      chars_ext = 32'(chars);
      rec.line_width    = sum_ext[OUT_PIX_W-1:0];
      rec.word_count    = words_ext[OUT_CNT_W-1:0];
      rec.char_count    = chars_ext[OUT_CNT_W-1:0];
      rec.line_height   = hgt;
      rec.line_ascender = asc;
      rec.wrapped       = wrapped;
      rec.last          = last;
      return rec;
   endfunction

   // handshakes
   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_tvalid && rsp_tready;
   assign s1_cls   = classify(s1_kind_ff, s1_code_ff);
   assign quiet    = (s1_cls == CLS_NORMAL) || (s1_cls == CLS_IGNORED);
   assign out_free = !s2a_valid_ff || (rsp_fire && !s2b_valid_ff);
   assign s1_go    = s1_valid_ff && (out_free || quiet);
   assign req_tready = !s1_valid_ff || s1_go;
   assign load     = s1_go && (res_cnt != 2'd0);

   // width test for closing a word
   assign gaps         = (line_words_ff == '0) ? CW'(1) : line_words_ff;
   assign spacing_prod = PROD_W'(min_spacing_ff) * PROD_W'(gaps);
   assign proposed     = SUM_W'(line_sum_ff) + SUM_W'(spacing_prod) + SUM_W'(word_sum_ff);
   assign overflow     = proposed >= SUM_W'(width_bound_ff);

   // line with the pending word merged in, saturating
   assign merged_sum_raw   = {1'b0, line_sum_ff} + {1'b0, word_sum_ff};
   assign merged_sum       = merged_sum_raw[PW] ? '1 : merged_sum_raw[PW-1:0];
   assign merged_words_raw = {1'b0, line_words_ff} + (CW+1)'(1);
   assign merged_words     = merged_words_raw[CW] ? '1 : merged_words_raw[CW-1:0];
   assign merged_chars_raw = {1'b0, line_chars_ff} + {1'b0, word_chars_ff};
   assign merged_chars     = merged_chars_raw[CW] ? '1 : merged_chars_raw[CW-1:0];
   assign merged_hgt       = (word_hgt_ff > line_hgt_ff) ? word_hgt_ff : line_hgt_ff;
   assign merged_asc       = (word_asc_ff > line_asc_ff) ? word_asc_ff : line_asc_ff;

   // pending word grown by one glyph
   assign word_sum_raw   = {1'b0, word_sum_ff} + (PW+1)'(s1_adv_ff);
   assign word_chars_raw = {1'b0, word_chars_ff} + (CW+1)'(1);

   // per-class update of state and results
   always_comb begin
      line_sum_in   = line_sum_ff;
      line_words_in = line_words_ff;
      line_chars_in = line_chars_ff;
      line_hgt_in   = line_hgt_ff;
      line_asc_in   = line_asc_ff;
      word_sum_in   = word_sum_ff;
      word_chars_in = word_chars_ff;
      word_hgt_in   = word_hgt_ff;
      word_asc_in   = word_asc_ff;
      res_cnt       = 2'd0;
      res0 = make_rec(line_sum_ff, line_words_ff, line_chars_ff, line_hgt_ff, line_asc_ff,
                      1'b0, 1'b1);
      res1 = make_rec(word_sum_ff, CW'(1), word_chars_ff, word_hgt_ff, word_asc_ff,
                      1'b0, 1'b1);
      case (s1_cls)
         CLS_NORMAL: begin
            word_sum_in   = word_sum_raw[PW] ? '1 : word_sum_raw[PW-1:0];
            word_chars_in = word_chars_raw[CW] ? '1 : word_chars_raw[CW-1:0];
            word_hgt_in   = (s1_hgt_ff > word_hgt_ff) ? s1_hgt_ff : word_hgt_ff;
            word_asc_in   = (s1_asc_ff > word_asc_ff) ? s1_asc_ff : word_asc_ff;
         end
         CLS_NEWLINE: begin
            res_cnt       = 2'd1;
            line_sum_in   = '0;
            line_words_in = '0;
            line_chars_in = '0;
            line_hgt_in   = '0;
            line_asc_in   = '0;
         end
         CLS_SPACE: begin
            word_sum_in   = '0;
            word_chars_in = '0;
            word_hgt_in   = '0;
            word_asc_in   = '0;
            if (overflow) begin
               res_cnt       = 2'd1;
               res0.wrapped  = 1'b1;
               line_sum_in   = word_sum_ff;
               line_words_in = CW'(1);
               line_chars_in = word_chars_ff;
               line_hgt_in   = word_hgt_ff;
               line_asc_in   = word_asc_ff;
            end else begin
               line_sum_in   = merged_sum;
               line_words_in = merged_words;
               line_chars_in = merged_chars;
               line_hgt_in   = merged_hgt;
               line_asc_in   = merged_asc;
            end
         end
         CLS_END: begin
            word_sum_in   = '0;
            word_chars_in = '0;
            word_hgt_in   = '0;
            word_asc_in   = '0;
            line_sum_in   = '0;
            line_words_in = '0;
            line_chars_in = '0;
            line_hgt_in   = '0;
            line_asc_in   = '0;
            if (overflow) begin
               res_cnt      = 2'd2;
               res0.wrapped = 1'b1;
               res0.last    = 1'b0;
            end else begin
               res_cnt = 2'd1;
               res0 = make_rec(merged_sum, merged_words, merged_chars, merged_hgt,
                               merged_asc, 1'b0, 1'b1);
            end
         end
         default: begin
            res_cnt = 2'd0;
         end
      endcase
   end

   // request register next value
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_kind_in  = s1_kind_ff;
      s1_code_in  = s1_code_ff;
      s1_adv_in   = s1_adv_ff;
      s1_hgt_in   = s1_hgt_ff;
      s1_asc_in   = s1_asc_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
         s1_kind_in  = req_tuser;
         s1_code_in  = req_tdata[CODE_W-1:0];
         s1_adv_in   = req_tdata[CODE_W +: METRIC_W];
         s1_hgt_in   = req_tdata[CODE_W+METRIC_W +: METRIC_W];
         s1_asc_in   = req_tdata[CODE_W+2*METRIC_W +: METRIC_W];
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
   end

   // result slots next value
   always_comb begin
      s2a_valid_in = s2a_valid_ff;
      s2a_rec_in   = s2a_rec_ff;
      s2b_valid_in = s2b_valid_ff;
      s2b_rec_in   = s2b_rec_ff;
      if (rsp_fire) begin
         if (s2b_valid_ff) begin
            s2a_rec_in   = s2b_rec_ff;
            s2b_valid_in = 1'b0;
         end else begin
            s2a_valid_in = 1'b0;
         end
      end
      if (load) begin
         s2a_valid_in = 1'b1;
         s2a_rec_in   = res0;
         s2b_valid_in = (res_cnt == 2'd2);
         s2b_rec_in   = res1;
      end
   end

   // register writes
   always_comb begin
      width_bound_in = width_bound_ff;
      min_spacing_in = min_spacing_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_WIDTH_BOUND: width_bound_in = csr_wdata;
            CSR_MIN_SPACING: min_spacing_in = csr_wdata[SPACING_W-1:0];
            default:         width_bound_in = width_bound_ff;
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_bound_ff <= WIDTH_BOUND_RST;
         min_spacing_ff <= MIN_SPACING_RST;
         s1_valid_ff    <= 1'b0;
         s2a_valid_ff   <= 1'b0;
         s2b_valid_ff   <= 1'b0;
         line_sum_ff    <= '0;
         line_words_ff  <= '0;
         line_chars_ff  <= '0;
         line_hgt_ff    <= '0;
         line_asc_ff    <= '0;
         word_sum_ff    <= '0;
         word_chars_ff  <= '0;
         word_hgt_ff    <= '0;
         word_asc_ff    <= '0;
      end else begin
         width_bound_ff <= width_bound_in;
         min_spacing_ff <= min_spacing_in;
         s1_valid_ff    <= s1_valid_in;
         s2a_valid_ff   <= s2a_valid_in;
         s2b_valid_ff   <= s2b_valid_in;
         if (s1_go) begin
            line_sum_ff   <= line_sum_in;
            line_words_ff <= line_words_in;
            line_chars_ff <= line_chars_in;
            line_hgt_ff   <= line_hgt_in;
            line_asc_ff   <= line_asc_in;
            word_sum_ff   <= word_sum_in;
            word_chars_ff <= word_chars_in;
            word_hgt_ff   <= word_hgt_in;
            word_asc_ff   <= word_asc_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_kind_ff <= s1_kind_in;
      s1_code_ff <= s1_code_in;
      s1_adv_ff  <= s1_adv_in;
      s1_hgt_ff  <= s1_hgt_in;
      s1_asc_ff  <= s1_asc_in;
      s2a_rec_ff <= s2a_rec_in;
      s2b_rec_ff <= s2b_rec_in;
   end

   // output ports
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = s2a_valid_ff;
   assign rsp_tdata  = {s2a_rec_ff.line_ascender, s2a_rec_ff.line_height,
                        s2a_rec_ff.char_count, s2a_rec_ff.word_count,
                        s2a_rec_ff.line_width};
   assign rsp_tuser  = s2a_rec_ff.wrapped;
   assign rsp_tlast  = s2a_rec_ff.last;

   // checks
   `ASSERT_IMPLIES(a_second_behind_head, s2b_valid_ff, s2a_valid_ff,
                   "second result slot filled while head is empty")
   `ASSERT_IMPLIES(a_pair_last_order, s2b_valid_ff,
                   !s2a_rec_ff.last && s2b_rec_ff.last,
                   "last flag misplaced in a two-line result")
   `ASSERT_IMPLIES(a_single_is_last, s2a_valid_ff && !s2b_valid_ff, s2a_rec_ff.last,
                   "lone result without last flag")
   `ASSERT_HOLDS(a_empty_line_clear,
                 (line_words_ff != '0) || ((line_sum_ff == '0) && (line_chars_ff == '0)),
                 "line without words holds width or characters")
   `ASSERT_NEXT(a_end_clears_state, s1_go && (s1_cls == CLS_END),
                (line_words_ff == '0) && (word_sum_ff == '0) && (word_chars_ff == '0),
                "state not cleared after end of text")

endmodule
